// ===== rtl/core/pwarp_pkg.sv =====
// ----------------------------------------------------------------------------
// pwarp_pkg
// Shared types and constants of the projective backward warp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pwarp_pkg;

    // quotient bits resolved by the dividers; larger quotients are out of range
    localparam int QBITS = 11;
    // exact width of a projected coordinate sum
    localparam int SUM_W = 67;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WARP = 1'b1;

    localparam logic [2:0] CFG_X_LO   = 3'd0;
    localparam logic [2:0] CFG_X_HI   = 3'd1;
    localparam logic [2:0] CFG_Y_LO   = 3'd2;
    localparam logic [2:0] CFG_Y_HI   = 3'd3;
    localparam logic [2:0] CFG_Z_LO   = 3'd4;
    localparam logic [2:0] CFG_Z_HI   = 3'd5;
    localparam logic [2:0] CFG_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_HEIGHT = 3'd7;

    typedef struct packed {
        logic               op;
        logic [9:0]         load_column;
        logic [8:0]         load_row;
        logic [7:0]         load_blue;
        logic [7:0]         load_green;
        logic [7:0]         load_red;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } t_out;

    // per-transaction control carried alongside the arithmetic
    typedef struct packed {
        logic        op;
        logic        zero;
        logic        nx;
        logic        ny;
        logic        nz;
        logic        ynz;
        logic        mzero;
        logic [9:0]  lcol;
        logic [8:0]  lrow;
        logic [23:0] lpix;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/pwarp_ram.sv =====
// ----------------------------------------------------------------------------
// pwarp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pwarp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pwarp_div.sv =====
// ----------------------------------------------------------------------------
// pwarp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// for quotients of more than QB bits and a zero-remainder flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pwarp_div #(
    parameter int QB = 11
) (
    input  wire logic          i_clk,
    input  wire logic [63:0]   i_num,
    input  wire logic [63:0]   i_den,
    output logic      [QB-1:0] o_q,
    output logic               o_ovf,
    output logic               o_exact
);

    localparam int CW = 64 + QB + 1;

    logic [63:0]   r_rem [QB+1];
    logic [63:0]   r_den [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];

    // stage j compares against the divisor shifted by QB-j
    logic [CW-1:0] sh [QB];
    logic          ge [QB];

    always_comb begin
        for (int j = 1; j <= QB; j++) begin
            sh[j-1] = CW'(r_den[j-1]) << (QB - j);
            ge[j-1] = CW'(r_rem[j-1]) >= sh[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << QB);
        for (int j = 1; j <= QB; j++) begin
            r_rem[j] <= ge[j-1] ? r_rem[j-1] - sh[j-1][63:0] : r_rem[j-1];
            r_den[j] <= r_den[j-1];
            r_q[j]   <= {r_q[j-1][QB-2:0], ge[j-1]};
            r_ovf[j] <= r_ovf[j-1];
        end
    end

    assign o_q     = r_q[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_exact = r_rem[QB] == '0;

endmodule

`default_nettype wire

// ===== rtl/core/projective_backward_warp_unit.sv =====
// ----------------------------------------------------------------------------
// projective_backward_warp_unit
// Loads RGB source pixels into an image store and maps warp points through
// a 3x4 camera matrix into that store, reporting hit and colour.
// ----------------------------------------------------------------------------
// Pipeline: a warp result strobes after capture; products, pair sums, full sum
// and magnitude; 12 divider stages, one decision stage and one image read.
// Throughput: one transaction per cycle; busy stays low, the divider is fully
// pipelined and loads and reads use the image store in the same stage.
// Reset clears pipeline valids and coefficients and sets the size to 640x480;
// the image store is not cleared and holds undefined data until loaded.
`default_nettype none

module projective_backward_warp_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pwarp_pkg::t_in   i_item,
    output logic                  o_valid,
    output pwarp_pkg::t_out       o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [63:0]      i_cfg_data
);

    localparam int QB    = pwarp_pkg::QBITS;
    localparam int SW    = pwarp_pkg::SUM_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);
    localparam logic [31:0]   MW32 = 32'(MAX_WIDTH);
    localparam logic [31:0]   MH32 = 32'(MAX_HEIGHT);

    // configuration
    logic [63:0] r_coef [6];
    logic [10:0] r_width;
    logic [9:0]  r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_coef[k] <= '0;
            end
            r_width  <= 11'd640;
            r_height <= 10'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwarp_pkg::CFG_X_LO:   r_coef[0] <= i_cfg_data;
                pwarp_pkg::CFG_X_HI:   r_coef[1] <= i_cfg_data;
                pwarp_pkg::CFG_Y_LO:   r_coef[2] <= i_cfg_data;
                pwarp_pkg::CFG_Y_HI:   r_coef[3] <= i_cfg_data;
                pwarp_pkg::CFG_Z_LO:   r_coef[4] <= i_cfg_data;
                pwarp_pkg::CFG_Z_HI:   r_coef[5] <= i_cfg_data;
                pwarp_pkg::CFG_WIDTH:  r_width   <= i_cfg_data[10:0];
                pwarp_pkg::CFG_HEIGHT: r_height  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: capture
    logic                r_v1;
    pwarp_pkg::t_side    r_sd1, n_sd1;
    logic signed [31:0]  r_x1, r_y1, r_z1;

    always_comb begin
        n_sd1       = '0;
        n_sd1.op    = i_item.op;
        n_sd1.zero  = (i_item.point_x == 0) && (i_item.point_y == 0)
                      && (i_item.point_z == 0);
        n_sd1.lcol  = i_item.load_column;
        n_sd1.lrow  = i_item.load_row;
        n_sd1.lpix  = {i_item.load_red, i_item.load_green, i_item.load_blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_x1  <= i_item.point_x;
        r_y1  <= i_item.point_y;
        r_z1  <= i_item.point_z;
        r_sd1 <= n_sd1;
    end

    // stage 2: products, stage 3: pair sums, stage 4: full sum, stage 5: magnitude
    logic                 r_v2, r_v3, r_v4, r_v5;
    pwarp_pkg::t_side     r_sd2, r_sd3, r_sd4, r_sd5, n_sd5;
    logic signed [63:0]   r_px [3];
    logic signed [63:0]   r_py [3];
    logic signed [63:0]   r_pz [3];
    logic signed [SW-1:0] r_a  [3];
    logic signed [SW-1:0] r_b  [3];
    logic signed [SW-1:0] r_s  [3];
    logic        [63:0]   r_mag [3];

    always_comb begin
        n_sd5       = r_sd4;
        n_sd5.nx    = r_s[0][SW-1];
        n_sd5.ny    = r_s[1][SW-1];
        n_sd5.nz    = r_s[2][SW-1];
        n_sd5.ynz   = r_s[1] != '0;
        n_sd5.mzero = r_s[2] == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
        r_sd2 <= r_sd1;
        r_sd3 <= r_sd2;
        r_sd4 <= r_sd3;
        for (int k = 0; k < 3; k++) begin
            r_px[k] <= r_x1 * $signed(r_coef[2*k][31:0]);
            r_py[k] <= r_y1 * $signed(r_coef[2*k][63:32]);
            r_pz[k] <= r_z1 * $signed(r_coef[2*k+1][31:0]);
            r_a[k]  <= SW'(r_px[k]) + SW'(r_py[k]);
            r_b[k]  <= SW'(r_pz[k])
                       + (SW'($signed(r_coef[2*k+1][63:32])) <<< FRAC_BITS);
            r_s[k]  <= r_a[k] + r_b[k];
            r_mag[k] <= r_s[k][SW-1] ? 64'(-r_s[k]) : r_s[k][63:0];
        end
        r_sd5 <= n_sd5;
    end

    // dividers: column X/Z and row Y/Z
    logic [QB-1:0] qc, qr;
    logic          ovf_c, ovf_r, ex_c, ex_r;

    pwarp_div #(.QB(QB)) u_div_col (
        .i_clk   (i_clk),
        .i_num   (r_mag[0]),
        .i_den   (r_mag[2]),
        .o_q     (qc),
        .o_ovf   (ovf_c),
        .o_exact (ex_c)
    );

    pwarp_div #(.QB(QB)) u_div_row (
        .i_clk   (i_clk),
        .i_num   (r_mag[1]),
        .i_den   (r_mag[2]),
        .o_q     (qr),
        .o_ovf   (ovf_r),
        .o_exact (ex_r)
    );

    logic             r_dv  [QB+1];
    pwarp_pkg::t_side r_dsd [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QB; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v5;
            for (int j = 1; j <= QB; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
        end
        r_dsd[0] <= r_sd5;
        for (int j = 1; j <= QB; j++) begin
            r_dsd[j] <= r_dsd[j-1];
        end
    end

    // decision
    pwarp_pkg::t_side sd;
    logic [10:0] col, h11, row;
    logic        col_miss, row_miss, hit;

    always_comb begin
        sd       = r_dsd[QB];
        h11      = {1'b0, r_height};
        col      = (sd.nx != sd.nz) ? '0 : 11'(qc);
        col_miss = ovf_c || ((sd.nx != sd.nz) && (qc != '0))
                   || (col >= r_width) || (32'(col) >= MW32);
        row      = '0;
        row_miss = ovf_r || ((sd.ny != sd.nz) && sd.ynz);
        if (ex_r) begin
            row_miss = row_miss || (qr == '0) || (11'(qr) > h11);
            row      = h11 - 11'(qr);
        end else begin
            row_miss = row_miss || (11'(qr) > h11) || (h11 == '0);
            row      = (11'(qr) < h11) ? h11 - 11'(qr) - 11'd1 : '0;
        end
        row_miss = row_miss || (row >= h11) || (32'(row) >= MH32);
        hit      = !sd.zero && !sd.mzero && !col_miss && !row_miss;
    end

    logic             r_ev, r_ehit;
    pwarp_pkg::t_side r_esd;
    logic [10:0]      r_ecol, r_erow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else begin
            r_ev <= r_dv[QB];
        end
        r_esd  <= sd;
        r_ehit <= hit;
        r_ecol <= col;
        r_erow <= row;
    end

    // image store: loads and warp reads meet it in the same stage, in order
    logic          ram_we, ram_re;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   rdata;

    assign ram_we = r_ev && (r_esd.op == pwarp_pkg::OP_LOAD)
                    && (32'(r_esd.lcol) < MW32) && (32'(r_esd.lrow) < MH32);
    assign ram_re = r_ev && (r_esd.op == pwarp_pkg::OP_WARP) && r_ehit;
    assign waddr  = AW'(r_esd.lrow) * MW_A + AW'(r_esd.lcol);
    assign raddr  = AW'(r_erow) * MW_A + AW'(r_ecol);

    pwarp_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_img (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (r_esd.lpix),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    logic r_ov, r_ohit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_ev && (r_esd.op == pwarp_pkg::OP_WARP);
        end
        r_ohit <= r_ehit;
    end

    assign o_valid            = r_ov;
    assign o_result.hit       = r_ohit;
    assign o_result.out_blue  = r_ohit ? rdata[7:0]   : 8'd0;
    assign o_result.out_green = r_ohit ? rdata[15:8]  : 8'd0;
    assign o_result.out_red   = r_ohit ? rdata[23:16] : 8'd0;

endmodule

`default_nettype wire
